// ----- rtl/core/tfsu_pkg.sv -----
// Shared types, constants and helpers for the traffic flow stencil update block.
`timescale 1ns / 1ps

package tfsu_pkg;

	// Grid size limit; the cell counter saturates at MAX_CELLS-1.
	localparam int MAX_CELLS = 1024;
	localparam int CNT_W = $clog2(MAX_CELLS);

	localparam int DENS_W = 16;
	localparam int COEF_W = 16;
	localparam int IDX_W = 10;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCHEME_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COURANT_COEFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_MAX_DENSITY = 2'd2;

	// Reset values of the configuration registers
	localparam logic [COEF_W-1:0] COURANT_RST = 16'd3277;
	localparam logic [COEF_W-1:0] INV_MAX_RST = 16'd4096;

	// Which stencil a result uses (left, center, right, index)
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_MID = 3'd0;   // older, newer, input; index cnt-1
	localparam kind_t KIND_LASTC = 3'd1; // newer, input, first; index cnt
	localparam kind_t KIND_WRAP = 3'd2;  // input, first, second; index 0
	localparam kind_t KIND_ONE = 3'd3;   // input on all three; index 0
	localparam kind_t KIND_TWO_A = 3'd4; // first, input, first; index 1
	localparam kind_t KIND_TWO_B = 3'd5; // input, first, input; index 0

	typedef struct packed {
		logic load;    // capture the input beat
		logic step_m1; // factor product
		logic step_m2; // factor times difference
		logic step_m3; // times Courant coefficient
		logic fin;     // finish result into output register
		logic commit;  // shift stencil state, advance counter
		kind_t kind;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cnt_is0;
		logic cnt_is1;
		logic last;
		logic out_free;
	} dp_status_t;

	// Result closes the sweep
	function automatic logic kind_done(input kind_t k);
		logic d;
		d = 1'b0;
		case (k)
			KIND_WRAP, KIND_ONE, KIND_TWO_B: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

	// Counter value to output index, masked to the index width
	function automatic logic [IDX_W-1:0] to_index(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[IDX_W-1:0];
	endfunction

endpackage

// ----- rtl/core/traffic_flow_stencil_update.sv -----
// Top level of the traffic flow stencil update block.
`timescale 1ns / 1ps

// One time step of a periodic 1-D traffic density grid. Cell densities
// (signed Q3.12) stream in on the slave side, cell 0 first, with tlast on
// the final cell; grids of one or two cells are handled too, and the
// index saturates at MAX_CELLS-1. Each beat of a cell k >= 2 yields
// updated cell k-1; the final beat yields cell k-1, cell k and then cell
// 0 (for k = 1, cell 1 and then cell 0; for k = 0, cell 0 alone), the
// last of these with tlast set and the sweep's largest |new - old| in
// max_change (zero on every other result). scheme_mode selects
// forward-time centred-space (0) or Lax averaging (1); courant_coeff is
// unsigned Q0.16 and inv_max_density unsigned Q4.12. Results are rounded
// half up and saturated. Each result runs on one shared multiplier as
// three dependent products and a finishing step. The slave side takes a
// new beat as soon as the previous one is fully processed, even while
// the last result still sits in the output register. Configuration
// writes belong in idle periods.
module traffic_flow_stencil_update (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] density
	input  logic        s_axis_tlast,  // last_cell
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [9:0] cell_index, [25:10] new_density,
	                                   // [41:26] max_change, [47:42] zero
	output logic        m_axis_tlast,  // sweep_done
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tfsu_pkg::ctrl_cmd_t cmd;
	tfsu_pkg::dp_status_t status;

	logic [tfsu_pkg::IDX_W-1:0] out_index;
	logic signed [tfsu_pkg::DENS_W-1:0] out_density;
	logic [tfsu_pkg::COEF_W-1:0] out_max;

	// Controller: accepts a beat when idle, then runs the multiply steps, or only commits cell 0 or 1 when not last
	tfsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: stencil registers, shared multiplier, output register
	tfsu_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_density  (signed'(s_axis_tdata)),
		.in_last     (s_axis_tlast),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_index   (out_index),
		.out_density (out_density),
		.out_max     (out_max),
		.out_done    (m_axis_tlast)
	);

	// pack result fields, lowest first, zero fill to whole bytes
	assign m_axis_tdata = {6'b0, out_max, unsigned'(out_density), out_index};

endmodule

// ----- rtl/core/tfsu_ctrl.sv -----
// Controller state machine: sequences the multiply steps of each result.
`timescale 1ns / 1ps

module tfsu_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_last,
	output logic                   in_ready,
	input  tfsu_pkg::dp_status_t   status,
	output tfsu_pkg::ctrl_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_M1 = 3'd1;
	localparam logic [2:0] ST_M2 = 3'd2;
	localparam logic [2:0] ST_M3 = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;

	logic [2:0] state_q, state_d;
	tfsu_pkg::kind_t kind_q, kind_d, kind_next;
	logic has_next;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// Follow-on result within the same input item
	always_comb begin
		has_next = 1'b0;
		kind_next = tfsu_pkg::KIND_MID;
		case (kind_q)
			tfsu_pkg::KIND_MID: begin
				has_next = status.last;
				kind_next = tfsu_pkg::KIND_LASTC;
			end
			tfsu_pkg::KIND_LASTC: begin
				has_next = 1'b1;
				kind_next = tfsu_pkg::KIND_WRAP;
			end
			tfsu_pkg::KIND_TWO_A: begin
				has_next = 1'b1;
				kind_next = tfsu_pkg::KIND_TWO_B;
			end
			default: begin
				has_next = 1'b0;
				kind_next = tfsu_pkg::KIND_MID;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		cmd = '0;
		cmd.kind = kind_q;
		cmd.load = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!in_last) begin
						kind_d = tfsu_pkg::KIND_MID;
						state_d = (status.cnt_is0 || status.cnt_is1) ? ST_COMMIT : ST_M1;
					end else begin
						if (status.cnt_is0) begin
							kind_d = tfsu_pkg::KIND_ONE;
						end else if (status.cnt_is1) begin
							kind_d = tfsu_pkg::KIND_TWO_A;
						end else begin
							kind_d = tfsu_pkg::KIND_MID;
						end
						state_d = ST_M1;
					end
				end
			end
			ST_M1: begin
				cmd.step_m1 = 1'b1;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.step_m2 = 1'b1;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.step_m3 = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.fin = 1'b1;
					if (has_next) begin
						kind_d = kind_next;
						state_d = ST_M1;
					end else begin
						cmd.commit = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= tfsu_pkg::KIND_MID;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
		end
	end

endmodule

// ----- rtl/core/tfsu_dp.sv -----
// Datapath: stencil state, config registers, shared multiplier, output register.
`timescale 1ns / 1ps

module tfsu_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tfsu_pkg::ctrl_cmd_t                   cmd,
	output tfsu_pkg::dp_status_t                  status,
	input  logic signed [tfsu_pkg::DENS_W-1:0]    in_density,
	input  logic                                  in_last,
	input  logic                                  cfg_we,
	input  logic [tfsu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tfsu_pkg::COEF_W-1:0]           cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [tfsu_pkg::IDX_W-1:0]            out_index,
	output logic signed [tfsu_pkg::DENS_W-1:0]    out_density,
	output logic [tfsu_pkg::COEF_W-1:0]           out_max,
	output logic                                  out_done
);

	localparam int CW = tfsu_pkg::CNT_W;
	localparam logic [CW-1:0] CNT_TOP = CW'(tfsu_pkg::MAX_CELLS - 1);
	localparam logic signed [34:0] F_ONE = 35'sd16777216;

	// config
	logic mode_q;
	logic [15:0] coeff_q, inv_q;

	// stencil state
	logic signed [15:0] first_q, second_q, older_q, newer_q, d_q;
	logic last_q;
	logic [CW-1:0] cnt_q;
	logic [15:0] run_max_q;

	// shared multiplier
	logic signed [51:0] p_q;
	logic signed [34:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [51:0] prod;

	logic signed [15:0] l_v, u_v, r_v;
	logic signed [16:0] sum_v, diff_v;
	logic signed [34:0] p_lo, f_v;
	logic signed [51:0] t_sum, term_sum;
	logic signed [27:0] t_v;
	logic signed [35:0] term_v;
	logic signed [17:0] sum_r;
	logic signed [16:0] base_v;
	logic signed [36:0] new_full;
	logic signed [15:0] nv;
	logic signed [16:0] dlt;
	logic [16:0] chg_abs;
	logic [15:0] chg, max_new;
	logic [CW-1:0] idx_c;
	logic out_valid_q, out_done_q;
	logic [tfsu_pkg::IDX_W-1:0] out_index_q;
	logic signed [15:0] out_density_q;
	logic [15:0] out_max_q;

	assign status.cnt_is0 = (cnt_q == '0);
	assign status.cnt_is1 = (cnt_q == CW'(1));
	assign status.last = last_q;
	assign status.out_free = !out_valid_q || out_ready;

	// stencil selection
	always_comb begin
		l_v = older_q;
		u_v = newer_q;
		r_v = d_q;
		idx_c = cnt_q - CW'(1);
		case (cmd.kind)
			tfsu_pkg::KIND_MID: begin
				l_v = older_q; u_v = newer_q; r_v = d_q; idx_c = cnt_q - CW'(1);
			end
			tfsu_pkg::KIND_LASTC: begin
				l_v = newer_q; u_v = d_q; r_v = first_q; idx_c = cnt_q;
			end
			tfsu_pkg::KIND_WRAP: begin
				l_v = d_q; u_v = first_q; r_v = second_q; idx_c = '0;
			end
			tfsu_pkg::KIND_ONE: begin
				l_v = d_q; u_v = d_q; r_v = d_q; idx_c = '0;
			end
			tfsu_pkg::KIND_TWO_A: begin
				l_v = first_q; u_v = d_q; r_v = first_q; idx_c = CW'(1);
			end
			tfsu_pkg::KIND_TWO_B: begin
				l_v = d_q; u_v = first_q; r_v = d_q; idx_c = '0;
			end
			default: begin
				l_v = older_q; u_v = newer_q; r_v = d_q; idx_c = cnt_q - CW'(1);
			end
		endcase
	end

	assign sum_v = 17'(r_v) + 17'(l_v);
	assign diff_v = 17'(r_v) - 17'(l_v);

	// step 2: density factor in Q.24
	assign p_lo = signed'(p_q[34:0]);
	assign f_v = F_ONE - (mode_q ? p_lo : (p_lo <<< 1));

	// step 3 and finish: round half up
	assign t_sum = p_q + 52'sd8388608;
	assign t_v = signed'(t_sum[51:24]);
	assign term_sum = p_q + 52'sd32768;
	assign term_v = signed'(term_sum[51:16]);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.step_m1) begin
			mul_a = mode_q ? 35'(sum_v) : 35'(u_v);
			mul_b = signed'({1'b0, inv_q});
		end else if (cmd.step_m2) begin
			mul_a = f_v;
			mul_b = diff_v;
		end else if (cmd.step_m3) begin
			mul_a = 35'(t_v);
			mul_b = signed'({1'b0, coeff_q});
		end
	end

	assign prod = 52'(mul_a) * 52'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.step_m1 || cmd.step_m2 || cmd.step_m3) begin
			p_q <= prod;
		end
	end

	// finish: base minus term, saturate, track change
	assign sum_r = 18'(sum_v) + 18'sd1;
	assign base_v = mode_q ? signed'(sum_r[17:1]) : 17'(u_v);
	assign new_full = 37'(base_v) - 37'(term_v);

	always_comb begin
		if (new_full > 37'sd32767) begin
			nv = 16'sh7FFF;
		end else if (new_full < -37'sd32768) begin
			nv = -16'sh8000;
		end else begin
			nv = new_full[15:0];
		end
	end

	assign dlt = 17'(nv) - 17'(u_v);
	assign chg_abs = (dlt < 0) ? unsigned'(-dlt) : unsigned'(dlt);
	assign chg = chg_abs[15:0];
	assign max_new = (chg > run_max_q) ? chg : run_max_q;

	// config and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			coeff_q <= tfsu_pkg::COURANT_RST;
			inv_q <= tfsu_pkg::INV_MAX_RST;
			cnt_q <= '0;
			run_max_q <= '0;
			out_valid_q <= 1'b0;
			first_q <= '0;
			second_q <= '0;
			older_q <= '0;
			newer_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tfsu_pkg::REG_SCHEME_MODE: mode_q <= cfg_data[0];
					tfsu_pkg::REG_COURANT_COEFF: coeff_q <= cfg_data;
					tfsu_pkg::REG_INV_MAX_DENSITY: inv_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.fin) begin
				run_max_q <= max_new;
			end
			if (cmd.commit) begin
				older_q <= newer_q;
				newer_q <= d_q;
				if (last_q) begin
					cnt_q <= '0;
					run_max_q <= '0;
				end else begin
					if (cnt_q == '0) first_q <= d_q;
					if (cnt_q == CW'(1)) second_q <= d_q;
					if (cnt_q != CNT_TOP) cnt_q <= cnt_q + CW'(1);
				end
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q <= in_density;
			last_q <= in_last;
		end
		if (cmd.fin) begin
			out_index_q <= tfsu_pkg::to_index(idx_c);
			out_density_q <= nv;
			out_done_q <= tfsu_pkg::kind_done(cmd.kind);
			out_max_q <= tfsu_pkg::kind_done(cmd.kind) ? max_new : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_density = out_density_q;
	assign out_max = out_max_q;
	assign out_done = out_done_q;

endmodule
